[rtl/jkvt_pkg.sv]
package jkvt_pkg;

	typedef enum logic [1:0] {
		RK_PAIR   = 2'd0,
		RK_ACCEPT = 2'd1,
		RK_FAIL   = 2'd2,
		RK_EMPTY  = 2'd3
	} result_kind_t;

	typedef enum logic [2:0] {
		VK_NULL   = 3'd0,
		VK_BOOL   = 3'd1,
		VK_INT    = 3'd2,
		VK_DOUBLE = 3'd3,
		VK_STRING = 3'd4
	} value_kind_t;

	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_NL     = 8'h0A;

	function automatic logic [7:0] lit_char(input logic [1:0] li, input logic [2:0] k);
		logic [7:0] c;
		c = 8'h00;
		case (li)
			2'd0: case (k)
				3'd0: c = "n"; 3'd1: c = "u"; 3'd2: c = "l"; 3'd3: c = "l";
				default: c = 8'h00;
			endcase
			2'd1: case (k)
				3'd0: c = "t"; 3'd1: c = "r"; 3'd2: c = "u"; 3'd3: c = "e";
				default: c = 8'h00;
			endcase
			2'd2: case (k)
				3'd0: c = "f"; 3'd1: c = "a"; 3'd2: c = "l"; 3'd3: c = "s";
				3'd4: c = "e";
				default: c = 8'h00;
			endcase
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

[rtl/jsonl_key_value_tokenizer.sv]
// JSON-lines flat-object tokenizer.
// in channel: in_valid/in_ready with data_byte and end_of_buffer, one byte per
// request. out channel: out_valid/out_ready, one result per request.
// The front stage classifies each byte combinationally and registers zero, one or
// two results in a single-entry queue; the back stage moves them one per cycle,
// while out_ready allows, into a registered output stage. A byte is taken every
// cycle unless the queue holds results not yet moved out, so a byte producing two
// results holds off the next byte until its second result is moved out.
// A result passes through the queue register and then the output register.
// Reset clears the parse state and byte offset; no result is pending.
// When out_ready is low the output stage holds its result, the queue fills
// behind it and in_ready drops.
// After a byte flagged end_of_buffer all parse state returns to reset and
// the next byte is offset zero.
module jsonl_key_value_tokenizer #(
	parameter int OFFSET_BITS = 32,
	parameter int DEPTH_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_buffer,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  result_kind,
	output logic [31:0] key_offset,
	output logic [31:0] key_length,
	output logic [31:0] value_offset,
	output logic [31:0] value_length,
	output logic [2:0]  value_kind,
	output logic        value_escaped,
	output logic        last_of_run
);

	logic                   rec_valid, rec_ready, rec0_esc;
	logic [1:0]             rec_n, rec0_kind, rec1_kind;
	logic [OFFSET_BITS-1:0] rec0_ko, rec0_kl, rec0_vo, rec0_vl;
	logic [2:0]             rec0_vk;

	jkvt_parser #(.OFFSET_BITS(OFFSET_BITS), .DEPTH_BITS(DEPTH_BITS)) u_parser (
		.clk, .arst_n, .in_valid, .in_ready, .in_byte(data_byte), .in_eob(end_of_buffer),
		.rec_valid, .rec_ready, .rec_n, .rec0_kind, .rec0_ko, .rec0_kl, .rec0_vo,
		.rec0_vl, .rec0_vk, .rec0_esc, .rec1_kind
	);

	jkvt_emitter #(.OFFSET_BITS(OFFSET_BITS)) u_emitter (
		.clk, .arst_n, .rec_valid, .rec_ready, .rec_n, .rec0_kind, .rec0_ko, .rec0_kl,
		.rec0_vo, .rec0_vl, .rec0_vk, .rec0_esc, .rec1_kind, .out_valid, .out_ready,
		.result_kind, .key_offset, .key_length, .value_offset, .value_length,
		.value_kind, .value_escaped, .last_of_run
	);

endmodule

[rtl/jkvt_parser.sv]
module jkvt_parser #(
	parameter int OFFSET_BITS = 32,
	parameter int DEPTH_BITS  = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             in_byte,
	input  logic                   in_eob,
	output logic                   rec_valid,
	input  logic                   rec_ready,
	output logic [1:0]             rec_n,
	output logic [1:0]             rec0_kind,
	output logic [OFFSET_BITS-1:0] rec0_ko,
	output logic [OFFSET_BITS-1:0] rec0_kl,
	output logic [OFFSET_BITS-1:0] rec0_vo,
	output logic [OFFSET_BITS-1:0] rec0_vl,
	output logic [2:0]             rec0_vk,
	output logic                   rec0_esc,
	output logic [1:0]             rec1_kind
);

	typedef enum logic [3:0] {
		PH_LINE, PH_SKIP, PH_KEY, PH_KEY_STR, PH_COLON, PH_VALUE,
		PH_LIT_NULL, PH_LIT_TRUE, PH_LIT_FALSE, PH_VAL_STR,
		PH_NUM_INT, PH_NUM_FRAC, PH_NUM_EXP_SIGN, PH_NUM_EXP,
		PH_NEST, PH_AFTER
	} phase_t;

	localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;
	localparam logic [OFFSET_BITS-1:0] ONE = OFFSET_BITS'(1);

	phase_t                  ph_q, ph_d;
	logic [OFFSET_BITS-1:0]  pos_q, pko_q, pkl_q, pvo_q;
	logic [OFFSET_BITS-1:0]  pko_d, pkl_d, pvo_d;
	logic [2:0]              lmi_q, lmi_d;
	logic [DEPTH_BITS-1:0]   nd_q, nd_d;
	logic                    sq_q, sq_d, ep_q, ep_d, es_q, es_d, dbl_q, dbl_d;

	logic [1:0]              n;
	logic [1:0]              k0, k1;
	logic [OFFSET_BITS-1:0]  vo, vl;
	logic [2:0]              vk;
	logic                    esc;
	logic                    ws, dig, fire;
	logic [1:0]              li;
	logic [7:0]              b;

	assign b    = in_byte;
	assign ws   = (b == " ") || (b == 8'h09) || (b == 8'h0D);
	assign dig  = (b >= "0") && (b <= "9");
	assign in_ready = !rec_valid || rec_ready;
	assign fire = in_valid && in_ready;
	assign li   = 2'(ph_q - PH_LIT_NULL);

	always_comb begin
		logic do_after, num_end, pair;
		ph_d = ph_q; pko_d = pko_q; pkl_d = pkl_q; pvo_d = pvo_q;
		lmi_d = lmi_q; nd_d = nd_q; sq_d = sq_q; ep_d = ep_q; es_d = es_q; dbl_d = dbl_q;
		n = 2'd0; k0 = jkvt_pkg::RK_PAIR; k1 = jkvt_pkg::RK_PAIR;
		vo = '0; vl = '0; vk = jkvt_pkg::VK_NULL; esc = 1'b0;
		do_after = 1'b0; num_end = 1'b0; pair = 1'b0;
		case (ph_q)
			PH_LINE: if (!ws) begin
				if (b == jkvt_pkg::CH_LBRACE) ph_d = PH_KEY;
				else begin n = 2'd1; k0 = jkvt_pkg::RK_FAIL;
					ph_d = (b == jkvt_pkg::CH_NL) ? PH_LINE : PH_SKIP; end
			end
			PH_SKIP: if (b == jkvt_pkg::CH_NL) ph_d = PH_LINE;
			PH_KEY: if (!ws) begin
				if (b == jkvt_pkg::CH_RBRACE) begin
					n = 2'd1; k0 = jkvt_pkg::RK_ACCEPT; ph_d = PH_SKIP;
				end else if (b == jkvt_pkg::CH_QUOTE) begin
					pko_d = pos_q + ONE; ep_d = 1'b0; ph_d = PH_KEY_STR;
				end else begin n = 2'd1; k0 = jkvt_pkg::RK_FAIL;
					ph_d = (b == jkvt_pkg::CH_NL) ? PH_LINE : PH_SKIP; end
			end
			PH_KEY_STR: begin
				if (ep_q) ep_d = 1'b0;
				else if (b == jkvt_pkg::CH_BSLASH) ep_d = 1'b1;
				else if (b == jkvt_pkg::CH_QUOTE) begin
					pkl_d = pos_q - pko_q; ph_d = PH_COLON;
				end
			end
			PH_COLON: if (!ws) begin
				if (b == jkvt_pkg::CH_COLON) ph_d = PH_VALUE;
				else begin n = 2'd1; k0 = jkvt_pkg::RK_FAIL;
					ph_d = (b == jkvt_pkg::CH_NL) ? PH_LINE : PH_SKIP; end
			end
			PH_VALUE: if (!ws) begin
				pvo_d = pos_q; lmi_d = 3'd1; es_d = 1'b0; ep_d = 1'b0; dbl_d = 1'b0;
				if (b == "n") ph_d = PH_LIT_NULL;
				else if (b == "t") ph_d = PH_LIT_TRUE;
				else if (b == "f") ph_d = PH_LIT_FALSE;
				else if (b == jkvt_pkg::CH_QUOTE) begin
					pvo_d = pos_q + ONE; ph_d = PH_VAL_STR;
				end else if (b == "-" || b == "+" || dig) ph_d = PH_NUM_INT;
				else if (b == jkvt_pkg::CH_LBRACK || b == jkvt_pkg::CH_LBRACE) begin
					nd_d = DEPTH_BITS'(1); sq_d = (b == jkvt_pkg::CH_LBRACK);
					ph_d = PH_NEST;
				end else begin n = 2'd1; k0 = jkvt_pkg::RK_FAIL;
					ph_d = (b == jkvt_pkg::CH_NL) ? PH_LINE : PH_SKIP; end
			end
			PH_LIT_NULL, PH_LIT_TRUE, PH_LIT_FALSE: begin
				if (lmi_q < 3'd6 && b == jkvt_pkg::lit_char(li, lmi_q)) begin
					lmi_d = lmi_q + 3'd1;
					if (lmi_d >= ((li == 2'd2) ? 3'd5 : 3'd4)) begin
						n = 2'd1; pair = 1'b1;
						if (li != 2'd0) begin
							vo = pvo_q; vl = (li == 2'd2) ? OFFSET_BITS'(5) : OFFSET_BITS'(4);
							vk = jkvt_pkg::VK_BOOL;
						end
						lmi_d = 3'd0; ph_d = PH_AFTER;
					end
				end else begin n = 2'd1; k0 = jkvt_pkg::RK_FAIL;
					ph_d = (b == jkvt_pkg::CH_NL) ? PH_LINE : PH_SKIP; end
			end
			PH_VAL_STR: begin
				if (ep_q) ep_d = 1'b0;
				else if (b == jkvt_pkg::CH_BSLASH) begin ep_d = 1'b1; es_d = 1'b1; end
				else if (b == jkvt_pkg::CH_QUOTE) begin
					n = 2'd1; pair = 1'b1; vo = pvo_q; vl = pos_q - pvo_q;
					vk = jkvt_pkg::VK_STRING; esc = es_q; ph_d = PH_AFTER;
				end
			end
			PH_NUM_INT: if (!dig) begin
				if (b == ".") begin dbl_d = 1'b1; ph_d = PH_NUM_FRAC; end
				else if (b == "e" || b == "E") begin dbl_d = 1'b1; ph_d = PH_NUM_EXP_SIGN; end
				else num_end = 1'b1;
			end
			PH_NUM_FRAC: if (!dig) begin
				if (b == "e" || b == "E") ph_d = PH_NUM_EXP_SIGN;
				else num_end = 1'b1;
			end
			PH_NUM_EXP_SIGN: begin
				if (b == "+" || b == "-" || dig) ph_d = PH_NUM_EXP;
				else num_end = 1'b1;
			end
			PH_NUM_EXP: if (!dig) num_end = 1'b1;
			PH_NEST: begin
				if (b == (sq_q ? jkvt_pkg::CH_LBRACK : jkvt_pkg::CH_LBRACE)) begin
					if (nd_q < DEPTH_MAX) nd_d = nd_q + DEPTH_BITS'(1);
				end else if (b == (sq_q ? jkvt_pkg::CH_RBRACK : jkvt_pkg::CH_RBRACE)) begin
					if (nd_q > '0) nd_d = nd_q - DEPTH_BITS'(1);
					if (nd_d == '0) begin n = 2'd1; pair = 1'b1; ph_d = PH_AFTER; end
				end
			end
			PH_AFTER: do_after = 1'b1;
			default: ph_d = PH_LINE;
		endcase
		if (num_end) begin
			n = 2'd1; pair = 1'b1; vo = pvo_q; vl = pos_q - pvo_q;
			vk = dbl_q ? jkvt_pkg::VK_DOUBLE : jkvt_pkg::VK_INT;
			ph_d = PH_AFTER; do_after = 1'b1;
		end
		if (do_after && !ws) begin
			if (b == jkvt_pkg::CH_COMMA) ph_d = PH_KEY;
			else if (b == jkvt_pkg::CH_RBRACE) begin
				if (n == 2'd0) k0 = jkvt_pkg::RK_ACCEPT; else k1 = jkvt_pkg::RK_ACCEPT;
				n = n + 2'd1; ph_d = PH_SKIP;
			end else begin
				if (n == 2'd0) k0 = jkvt_pkg::RK_FAIL; else k1 = jkvt_pkg::RK_FAIL;
				n = n + 2'd1; ph_d = (b == jkvt_pkg::CH_NL) ? PH_LINE : PH_SKIP;
			end
		end
		if (in_eob) begin
			if (ph_d == PH_LINE || ph_d == PH_SKIP) begin
				if (n == 2'd0) begin n = 2'd1; k0 = jkvt_pkg::RK_EMPTY; end
			end else if (ph_d == PH_NUM_INT || ph_d == PH_NUM_FRAC ||
					ph_d == PH_NUM_EXP_SIGN || ph_d == PH_NUM_EXP) begin
				if (n == 2'd0) begin
					n = 2'd1; pair = 1'b1; vo = pvo_d; vl = pos_q + ONE - pvo_d;
					vk = dbl_d ? jkvt_pkg::VK_DOUBLE : jkvt_pkg::VK_INT;
				end
				if (n == 2'd1) begin k1 = jkvt_pkg::RK_FAIL; n = 2'd2; end
			end else begin
				if (n == 2'd0) k0 = jkvt_pkg::RK_FAIL; else if (n == 2'd1) k1 = jkvt_pkg::RK_FAIL;
				if (n != 2'd2) n = n + 2'd1;
			end
		end
		if (!pair) esc = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_LINE; pos_q <= '0; pko_q <= '0; pkl_q <= '0; pvo_q <= '0;
			lmi_q <= '0; nd_q <= '0; sq_q <= 1'b0; ep_q <= 1'b0; es_q <= 1'b0;
			dbl_q <= 1'b0; rec_valid <= 1'b0;
		end else begin
			if (fire) begin
				if (in_eob) begin
					ph_q <= PH_LINE; pos_q <= '0; pko_q <= '0; pkl_q <= '0; pvo_q <= '0;
					lmi_q <= '0; nd_q <= '0; sq_q <= 1'b0; ep_q <= 1'b0;
					es_q <= 1'b0; dbl_q <= 1'b0;
				end else begin
					ph_q <= ph_d; pos_q <= pos_q + ONE; pko_q <= pko_d; pkl_q <= pkl_d;
					pvo_q <= pvo_d; lmi_q <= lmi_d; nd_q <= nd_d; sq_q <= sq_d;
					ep_q <= ep_d; es_q <= es_d; dbl_q <= dbl_d;
				end
				rec_valid <= (n != 2'd0);
			end else if (rec_valid && rec_ready) begin
				rec_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rec_n <= n; rec0_kind <= k0; rec1_kind <= k1;
			rec0_ko <= (k0 == jkvt_pkg::RK_PAIR) ? pko_q : '0;
			rec0_kl <= (k0 == jkvt_pkg::RK_PAIR) ? pkl_q : '0;
			rec0_vo <= vo; rec0_vl <= vl; rec0_vk <= vk; rec0_esc <= esc;
		end
	end

endmodule

[rtl/jkvt_emitter.sv]
module jkvt_emitter #(
	parameter int OFFSET_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   rec_valid,
	output logic                   rec_ready,
	input  logic [1:0]             rec_n,
	input  logic [1:0]             rec0_kind,
	input  logic [OFFSET_BITS-1:0] rec0_ko,
	input  logic [OFFSET_BITS-1:0] rec0_kl,
	input  logic [OFFSET_BITS-1:0] rec0_vo,
	input  logic [OFFSET_BITS-1:0] rec0_vl,
	input  logic [2:0]             rec0_vk,
	input  logic                   rec0_esc,
	input  logic [1:0]             rec1_kind,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [1:0]             result_kind,
	output logic [31:0]            key_offset,
	output logic [31:0]            key_length,
	output logic [31:0]            value_offset,
	output logic [31:0]            value_length,
	output logic [2:0]             value_kind,
	output logic                   value_escaped,
	output logic                   last_of_run
);

	logic idx_q;
	logic last;
	logic room;
	logic take;

	assign last = (rec_n == 2'd1) || idx_q;
	assign room = !out_valid || out_ready;
	assign take = rec_valid && room;
	assign rec_ready = room && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 1'b0;
			out_valid <= 1'b0;
		end else if (take) begin
			idx_q <= !last;
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			last_of_run <= last;
			if (idx_q) begin
				result_kind <= rec1_kind;
				key_offset <= '0; key_length <= '0; value_offset <= '0; value_length <= '0;
				value_kind <= jkvt_pkg::VK_NULL; value_escaped <= 1'b0;
			end else begin
				result_kind <= rec0_kind;
				key_offset <= 32'(rec0_ko); key_length <= 32'(rec0_kl);
				value_offset <= 32'(rec0_vo); value_length <= 32'(rec0_vl);
				value_kind <= rec0_vk; value_escaped <= rec0_esc;
			end
		end
	end

endmodule
